[sv/fca_pkg.sv]
// ---------------------------------------------------------------------------
// fca_pkg: shared types and constants of the failsafe command arbiter
// Command and source codes, field widths, item layouts and the structs that
// run between the controller, the table memories and the output buffer.
// ---------------------------------------------------------------------------
package fca_pkg;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int SRC_W     = 2;
	localparam int IDX_FW    = 3;
	localparam int VAL_W     = 32;
	localparam int TIME_W    = 64;
	localparam int CNT_W     = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 64;

	// Channel index space of the element_index field
	localparam int INDEX_SPACE       = 8;
	localparam int DEF_MAX_ACTUATORS = 8;

	// Stream layouts
	localparam int S_TDATA_W = 104;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 2;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_ACT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'b1;
	localparam logic [CNT_W-1:0]     RST_ACT_COUNT = 4'd8;
	localparam logic [TIME_W-1:0]    RST_TIMEOUT   = 64'd100000000;

	// Control sources
	localparam logic [SRC_W-1:0] SRC_NONE = 2'd0;
	localparam logic [SRC_W-1:0] SRC_DEMO = 2'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_SELECT = 2'd0,
		CMD_SUBMIT = 2'd1,
		CMD_GET    = 2'd2,
		CMD_LOAD   = 2'd3
	} cmd_t;

	// One result item
	typedef struct packed {
		logic              accepted;
		logic              cmd_valid;
		logic [IDX_FW-1:0] index;
		logic [VAL_W-1:0]  value;
		logic              last;
	} result_t;

	// Output buffer status seen by the controller
	typedef struct packed {
		logic [1:0] count;
		logic       pop;
	} buf_stat_t;

	// Table memory access request
	typedef struct packed {
		logic              cmd_we;
		logic [IDX_FW-1:0] cmd_waddr;
		logic [VAL_W-1:0]  cmd_wdata;
		logic              safe_we;
		logic [IDX_FW-1:0] safe_waddr;
		logic [VAL_W-1:0]  safe_wdata;
		logic              rd_en;
		logic [IDX_FW-1:0] rd_addr;
	} tab_req_t;

endpackage

[sv/fca_tables.sv]
// ---------------------------------------------------------------------------
// fca_tables: command and safe-value table memories
// Two single-port-write memories with a registered read at a shared address.
// ---------------------------------------------------------------------------
module fca_tables import fca_pkg::*; #(
	parameter int DEPTH = DEF_MAX_ACTUATORS
) (
	input  logic             clk,
	input  tab_req_t         req,
	output logic [VAL_W-1:0] cmd_rd,
	output logic [VAL_W-1:0] safe_rd
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [VAL_W-1:0] cmd_mem  [DEPTH];
	logic [VAL_W-1:0] safe_mem [DEPTH];
	logic [VAL_W-1:0] cmd_rd_q;
	logic [VAL_W-1:0] safe_rd_q;

	// Command table
	always_ff @(posedge clk) begin
		if (req.cmd_we) begin
			cmd_mem[req.cmd_waddr[IDX_W-1:0]] <= req.cmd_wdata;
		end
		if (req.rd_en) begin
			cmd_rd_q <= cmd_mem[req.rd_addr[IDX_W-1:0]];
		end
	end

	// Safe-value table
	always_ff @(posedge clk) begin
		if (req.safe_we) begin
			safe_mem[req.safe_waddr[IDX_W-1:0]] <= req.safe_wdata;
		end
		if (req.rd_en) begin
			safe_rd_q <= safe_mem[req.rd_addr[IDX_W-1:0]];
		end
	end

	assign cmd_rd  = cmd_rd_q;
	assign safe_rd = safe_rd_q;

endmodule

[sv/fca_outbuf.sv]
// ---------------------------------------------------------------------------
// fca_outbuf: two-entry result buffer
// Decouples result production from downstream stalls.
// ---------------------------------------------------------------------------
module fca_outbuf import fca_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  result_t   push_item,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   out_item,
	output buf_stat_t stat
);

	result_t    ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign out_item  = ent_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign stat      = '{count: count_q, pop: pop};

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	// No item is written into a full buffer unless one leaves
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && count_q == 2'd2) |-> pop)
		else $error("result buffer overflow");

endmodule

[sv/fca_ctrl.sv]
// ---------------------------------------------------------------------------
// fca_ctrl: command sequencer of the failsafe command arbiter
// Holds source, timestamp and configuration, decodes items and drives the
// table memories through read, copy and write-back steps.
// ---------------------------------------------------------------------------
module fca_ctrl import fca_pkg::*; #(
	parameter int DEPTH = DEF_MAX_ACTUATORS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	output tab_req_t             tab_req,
	input  logic [VAL_W-1:0]     cmd_rd,
	input  logic [VAL_W-1:0]     safe_rd,
	input  buf_stat_t            buf_stat,
	output logic                 push,
	output result_t              push_item
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_SWEEP  = 5'b00100,
		ST_GET    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	// Result issue slot, registered ahead of the buffer push
	typedef struct packed {
		logic              vld;
		logic              from_mem;
		logic              use_safe;
		logic              accepted;
		logic              cmd_valid;
		logic [IDX_FW-1:0] index;
		logic              last;
	} iss_t;

	state_t state_q, state_d;

	// Architectural state and configuration
	logic [SRC_W-1:0]  active_src_q;
	logic [TIME_W-1:0] last_time_q;
	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] timeout_q;

	// Captured item
	cmd_t              cmd_q;
	logic [SRC_W-1:0]  src_q;
	logic [IDX_FW-1:0] idx_q;
	logic [VAL_W-1:0]  val_q;
	logic [TIME_W-1:0] now_q;
	logic              live_q;

	logic [IDX_FW-1:0] cnt_q;
	iss_t              iss, iss_s1;
	logic              copy_vld_s1;
	logic [IDX_FW-1:0] copy_addr_s1;

	logic [CNT_W-1:0]  n_chan;
	logic [IDX_FW-1:0] n_last;
	logic              credit;
	logic              idx_ok, sub_ok, sel_ok, live;
	logic [TIME_W-1:0] age;
	logic              exec_go;
	logic              copy_go;
	logic              cnt_clr, cnt_inc;
	logic [2:0]        fill;

	// Channel count, clamped to 1..DEPTH
	always_comb begin
		n_chan = count_q;
		if (count_q == '0) begin
			n_chan = CNT_W'(1);
		end else if (count_q > CNT_W'(DEPTH)) begin
			n_chan = CNT_W'(DEPTH);
		end
	end
	assign n_last = IDX_FW'(n_chan - CNT_W'(1));

	// Room for one more result counting the one in flight
	assign fill   = {1'b0, buf_stat.count} + {2'b0, iss_s1.vld};
	assign credit = (fill - {2'b0, buf_stat.pop}) <= 3'd1;

	// Decode of the captured item
	assign idx_ok = ({1'b0, idx_q} < n_chan);
	assign sel_ok = (src_q != SRC_NONE);
	assign sub_ok = sel_ok && (src_q == active_src_q) && (now_q != '0) && idx_ok;
	assign age    = now_q - last_time_q;
	assign live   = (active_src_q == SRC_DEMO) ||
	                ((last_time_q != '0) && !(age > timeout_q));

	assign exec_go = (state_q == ST_EXEC) && credit;

	// Sequencer
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		iss      = '0;
		tab_req  = '0;
		copy_go  = 1'b0;
		cnt_clr  = 1'b0;
		cnt_inc  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cnt_clr = 1'b1;
				if (credit) begin
					unique case (cmd_q)
						CMD_SELECT: begin
							if (sel_ok) begin
								state_d = ST_SWEEP;
							end else begin
								iss.vld  = 1'b1;
								iss.last = 1'b1;
								state_d  = ST_IDLE;
							end
						end
						CMD_SUBMIT: begin
							tab_req.cmd_we    = sub_ok;
							tab_req.cmd_waddr = idx_q;
							tab_req.cmd_wdata = val_q;
							iss.vld      = 1'b1;
							iss.accepted = sub_ok;
							iss.last     = 1'b1;
							state_d      = ST_IDLE;
						end
						CMD_GET: begin
							state_d = ST_GET;
						end
						CMD_LOAD: begin
							tab_req.cmd_we     = idx_ok;
							tab_req.cmd_waddr  = idx_q;
							tab_req.cmd_wdata  = val_q;
							tab_req.safe_we    = idx_ok;
							tab_req.safe_waddr = idx_q;
							tab_req.safe_wdata = val_q;
							iss.vld      = 1'b1;
							iss.accepted = idx_ok;
							iss.last     = 1'b1;
							state_d      = ST_IDLE;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SWEEP: begin
				tab_req.rd_en   = 1'b1;
				tab_req.rd_addr = cnt_q;
				copy_go = 1'b1;
				cnt_inc = 1'b1;
				if (cnt_q == n_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_GET: begin
				if (credit) begin
					tab_req.rd_en   = 1'b1;
					tab_req.rd_addr = cnt_q;
					iss.vld       = 1'b1;
					iss.from_mem  = 1'b1;
					iss.use_safe  = !live_q;
					iss.cmd_valid = live_q;
					iss.index     = cnt_q;
					iss.last      = (cnt_q == n_last);
					cnt_inc       = 1'b1;
					if (cnt_q == n_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FINISH: begin
				if (credit) begin
					iss.vld      = 1'b1;
					iss.accepted = 1'b1;
					iss.last     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// Write back a restored safe value in the cycle after its read
		if (copy_vld_s1) begin
			tab_req.cmd_we    = 1'b1;
			tab_req.cmd_waddr = copy_addr_s1;
			tab_req.cmd_wdata = safe_rd;
		end
	end

	// Control state, source, timestamp, issue slot and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_src_q <= SRC_DEMO;
			last_time_q  <= '0;
			count_q      <= RST_ACT_COUNT;
			timeout_q    <= RST_TIMEOUT;
			cnt_q        <= '0;
			iss_s1       <= '0;
			copy_vld_s1  <= 1'b0;
		end else begin
			state_q     <= state_d;
			iss_s1      <= iss;
			copy_vld_s1 <= copy_go;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + IDX_FW'(1);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACT_COUNT: count_q   <= cfg_data[CNT_W-1:0];
					REG_TIMEOUT:   timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (exec_go) begin
				if (cmd_q == CMD_SELECT && sel_ok) begin
					active_src_q <= src_q;
					last_time_q  <= '0;
				end else if (cmd_q == CMD_SUBMIT && sub_ok && idx_q == n_last) begin
					last_time_q <= now_q;
				end
			end
		end
	end

	// Item capture and restore address
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= cmd_t'(s_tuser[1:0]);
			src_q <= s_tuser[3:2];
			idx_q <= s_tdata[2:0];
			val_q <= s_tdata[34:3];
			now_q <= s_tdata[98:35];
		end
		if (exec_go) begin
			live_q <= live;
		end
		copy_addr_s1 <= cnt_q;
	end

	// Buffer push
	assign push = iss_s1.vld;
	always_comb begin
		push_item           = '0;
		push_item.accepted  = iss_s1.accepted;
		push_item.cmd_valid = iss_s1.cmd_valid;
		push_item.index     = iss_s1.index;
		push_item.last      = iss_s1.last;
		if (iss_s1.from_mem) begin
			push_item.value = iss_s1.use_safe ? safe_rd : cmd_rd;
		end
	end

	// Buffered plus in-flight results never exceed the buffer depth
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, buf_stat.count} + {2'b0, iss_s1.vld}) <= 3'd2)
		else $error("result credit exceeded");

	// Safe-value restore writes only follow a sweep read
	a_copy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> (state_q == ST_SWEEP || state_q == ST_FINISH))
		else $error("restore write outside select sweep");

	// A sweep never overlaps a new item
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |=> !$past(s_tready))
		else $error("item taken during sweep");

endmodule

[sv/failsafe_command_arbiter_core.sv]
// ---------------------------------------------------------------------------
// failsafe_command_arbiter_core: actuator command guard with safe fallback
// Sequence: a submit, load or rejected select result is issued in the execute
//   state, registered in the issue slot and then pushed into the output buffer;
//   get results follow one per cycle while the buffer has room. A new item is
//   taken only in idle, after the last one is through; get and an accepted select
//   step through the channels in use, one table memory read per channel.
// Reset: source demo mission, timestamp 0, registers to defaults; table
//   contents stay undefined until loaded, there is no clearing pass.
// ---------------------------------------------------------------------------
module failsafe_command_arbiter_core import fca_pkg::*; #(
	parameter int MAX_ACTUATORS = DEF_MAX_ACTUATORS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// Input items
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // element_index[2:0], value[34:3], now_time[98:35]
	input  logic [S_TUSER_W-1:0] s_tuser,  // cmd[1:0], source[3:2]
	// Result items
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // out_index[2:0], out_value[34:3]
	output logic [M_TUSER_W-1:0] m_tuser,  // accepted[0], cmd_valid[1]
	output logic                 m_tlast
);

	localparam int DEPTH = (MAX_ACTUATORS < INDEX_SPACE) ? MAX_ACTUATORS : INDEX_SPACE;

	tab_req_t         tab_req;
	logic [VAL_W-1:0] cmd_rd;
	logic [VAL_W-1:0] safe_rd;
	buf_stat_t        buf_stat;
	logic             push;
	result_t          push_item;
	result_t          out_item;

	fca_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.tab_req  (tab_req),
		.cmd_rd   (cmd_rd),
		.safe_rd  (safe_rd),
		.buf_stat (buf_stat),
		.push     (push),
		.push_item(push_item)
	);

	fca_tables #(
		.DEPTH(DEPTH)
	) u_tables (
		.clk    (clk),
		.req    (tab_req),
		.cmd_rd (cmd_rd),
		.safe_rd(safe_rd)
	);

	fca_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_item (out_item),
		.stat     (buf_stat)
	);

	// Result packing
	assign m_tdata = {5'b0, out_item.value, out_item.index};
	assign m_tuser = {out_item.cmd_valid, out_item.accepted};
	assign m_tlast = out_item.last;

endmodule

[tb/tb_failsafe_command_arbiter_core.sv]
// ---------------------------------------------------------------------------
// tb_failsafe_command_arbiter_core: self-checking bench of the command guard
// Drives select, submit, get and safe-load items through the input stream,
// keeps its own copy of the source, timestamp and both tables, and compares
// every result item field by field in order. Both stream sides idle at
// random, and the registers are rewritten between phases while the block is
// idle.
// ---------------------------------------------------------------------------
package fca_arbiter_tb_pkg;
	import fca_pkg::*;

	// Sources without a name in the design package
	localparam logic [SRC_W-1:0] SRC_SIM  = 2'd2;
	localparam logic [SRC_W-1:0] SRC_PHYS = 2'd3;

	typedef struct packed {
		cmd_t              cmd;
		logic [SRC_W-1:0]  src;
		logic [IDX_FW-1:0] idx;
		logic [VAL_W-1:0]  value;
		logic [TIME_W-1:0] now;
	} arb_item_t;

	// Tracks the guard state and the queue of result items still owed
	class command_guard_model;
		logic [CNT_W-1:0]  chan_cfg;
		logic [TIME_W-1:0] max_age;
		logic [SRC_W-1:0]  sel_src;
		logic [TIME_W-1:0] stamp;
		logic [VAL_W-1:0]  cmd_vals  [INDEX_SPACE];
		logic [VAL_W-1:0]  safe_vals [INDEX_SPACE];
		result_t           pending_outputs [$];
		int unsigned       errors;

		function new();
			chan_cfg = RST_ACT_COUNT;
			max_age  = RST_TIMEOUT;
			sel_src  = SRC_DEMO;
			stamp    = '0;
			errors   = 0;
			foreach (cmd_vals[i]) begin
				cmd_vals[i]  = '0;
				safe_vals[i] = '0;
			end
		endfunction

		// Channels in use: 0 counts as 1, anything above the table clamps
		function int unsigned channels();
			int unsigned n;
			n = chan_cfg;
			if (n == 0) n = 1;
			if (n > DEF_MAX_ACTUATORS) n = DEF_MAX_ACTUATORS;
			if (n > INDEX_SPACE) n = INDEX_SPACE;
			return n;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_ACT_COUNT) chan_cfg = data[CNT_W-1:0];
			else if (idx == REG_TIMEOUT) max_age = data;
		endfunction

		// Demo source is always live; others go stale on no stamp or old stamp
		function bit commands_live(logic [TIME_W-1:0] now);
			logic [TIME_W-1:0] age;
			age = now - stamp;
			if (sel_src == SRC_DEMO) return 1'b1;
			return !(stamp == '0 || age > max_age);
		endfunction

		// Accepted input item: update state, queue the results it owes
		function void take_item(arb_item_t it);
			int unsigned n;
			bit          ok;
			bit          live;
			result_t     r;
			n  = channels();
			ok = 1'b0;
			case (it.cmd)
				CMD_SELECT: begin
					if (it.src != SRC_NONE) begin
						sel_src = it.src;
						stamp   = '0;
						for (int i = 0; i < n; i++) cmd_vals[i] = safe_vals[i];
						ok = 1'b1;
					end
				end
				CMD_SUBMIT: begin
					if (it.src != SRC_NONE && it.src == sel_src && it.now != '0 &&
					    it.idx < n) begin
						cmd_vals[it.idx] = it.value;
						if (it.idx == n - 1) stamp = it.now;
						ok = 1'b1;
					end
				end
				CMD_GET: begin
					live = commands_live(it.now);
					for (int i = 0; i < n; i++) begin
						r.accepted  = 1'b0;
						r.cmd_valid = live;
						r.index     = i[IDX_FW-1:0];
						r.value     = live ? cmd_vals[i] : safe_vals[i];
						r.last      = (i == n - 1);
						pending_outputs.push_back(r);
					end
					return;
				end
				CMD_LOAD: begin
					if (it.idx < n) begin
						safe_vals[it.idx] = it.value;
						cmd_vals[it.idx]  = it.value;
						ok = 1'b1;
					end
				end
			endcase
			r          = '0;
			r.accepted = ok;
			r.last     = 1'b1;
			pending_outputs.push_back(r);
		endfunction

		// Accepted result item: compare against the oldest one owed
		function void check_output(result_t got);
			result_t want;
			if (pending_outputs.size() == 0) begin
				$error("result item with none expected: %p", got);
				errors++;
				return;
			end
			want = pending_outputs.pop_front();
			if (got.accepted !== want.accepted) begin
				$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
				errors++;
			end
			if (got.cmd_valid !== want.cmd_valid) begin
				$error("cmd_valid: expected %0d, got %0d", want.cmd_valid, got.cmd_valid);
				errors++;
			end
			if (got.index !== want.index) begin
				$error("out_index: expected %0d, got %0d", want.index, got.index);
				errors++;
			end
			if (got.value !== want.value) begin
				$error("out_value: expected %08h, got %08h", want.value, got.value);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

endpackage

module tb_failsafe_command_arbiter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import fca_pkg::*;
	import fca_arbiter_tb_pkg::*;

	localparam int PAD_W = S_TDATA_W - IDX_FW - VAL_W - TIME_W;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;  // element_index[2:0], value[34:3], now_time[98:35]
	logic [S_TUSER_W-1:0] s_tuser;  // cmd[1:0], source[3:2]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;  // out_index[2:0], out_value[34:3]
	logic [M_TUSER_W-1:0] m_tuser;  // accepted[0], cmd_valid[1]
	logic                 m_tlast;

	command_guard_model guard = new();
	bit                 quiet = 1'b0;  // final phase: no idling on either side

	// Register settings per phase
	logic [CNT_W-1:0]  count_plan [6] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd8};
	logic [TIME_W-1:0] age_plan   [6] = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1,
	                                      64'd5000, 64'd20000, 64'd100000000};

	failsafe_command_arbiter_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#3ms;
		$display("tb_failsafe_command_arbiter_core: FAIL");
		$finish;
	end

	// Result monitor
	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.accepted  = m_tuser[0];
			got.cmd_valid = m_tuser[1];
			got.index     = m_tdata[IDX_FW-1:0];
			got.value     = m_tdata[IDX_FW +: VAL_W];
			got.last      = m_tlast;
			guard.check_output(got);
		end
	end

	// Receiver: ready with random stall bursts
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	function automatic logic [TIME_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic arb_item_t mk(cmd_t c, logic [SRC_W-1:0] s, logic [IDX_FW-1:0] i,
	                                 logic [VAL_W-1:0] v, logic [TIME_W-1:0] t);
		arb_item_t it;
		it.cmd   = c;
		it.src   = s;
		it.idx   = i;
		it.value = v;
		it.now   = t;
		return it;
	endfunction

	// Present one item, with an occasional gap first, and wait for acceptance
	task automatic send_item(arb_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {it.src, it.cmd};
		s_tdata  <= {{PAD_W{1'b0}}, it.now, it.value, it.idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		guard.take_item(it);
	endtask

	// Hold input, drain all owed results, let a select restore finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (guard.pending_outputs.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		guard.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Mostly whole submit frames and gets around the timeout edge, some noise
	task automatic random_items(int unsigned count);
		int unsigned       made;
		int unsigned       pick;
		int unsigned       n;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] d;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			n    = guard.channels();
			if (pick < 38) begin
				t = ($urandom_range(0, 3) == 0) ? rand64() :
				    guard.stamp + TIME_W'($urandom_range(1, 5000));
				for (int k = 0; k < n; k++)
					send_item(mk(CMD_SUBMIT, guard.sel_src, k[IDX_FW-1:0], $urandom, t));
				made += n;
			end else if (pick < 62) begin
				case ($urandom_range(0, 5))
					0:       d = '0;
					1:       d = guard.max_age;
					2:       d = guard.max_age + 1;
					3:       d = TIME_W'($urandom_range(0, 3000));
					4:       d = rand64();
					default: d = guard.max_age - TIME_W'($urandom_range(0, 2));
				endcase
				send_item(mk(CMD_GET, SRC_W'($urandom), IDX_FW'($urandom), $urandom,
				             guard.stamp + d));
				made++;
			end else if (pick < 72) begin
				send_item(mk(CMD_SELECT, SRC_W'($urandom_range(0, 3)), IDX_FW'($urandom),
				             $urandom, rand64()));
				made++;
			end else if (pick < 82) begin
				send_item(mk(CMD_LOAD, SRC_W'($urandom), IDX_FW'($urandom_range(0, 7)),
				             $urandom, rand64()));
				made++;
			end else if (pick < 91) begin
				// lone or stray submit: wrong source, zero time, any channel
				t = ($urandom_range(0, 2) == 0) ? '0 : rand64();
				send_item(mk(CMD_SUBMIT,
				             ($urandom_range(0, 1) == 0) ? guard.sel_src :
				                                           SRC_W'($urandom_range(0, 3)),
				             IDX_FW'($urandom_range(0, 7)), $urandom, t));
				made++;
			end else begin
				send_item(mk(cmd_t'(CMD_W'($urandom_range(0, 3))), SRC_W'($urandom),
				             IDX_FW'($urandom), $urandom, rand64()));
				made++;
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every safe entry before anything reads the tables
		send_item(mk(CMD_LOAD, SRC_NONE, 3'd0, 32'h0000_0000, 64'd0));
		send_item(mk(CMD_LOAD, SRC_NONE, 3'd1, 32'hFFFF_FFFF, 64'd0));
		send_item(mk(CMD_LOAD, SRC_DEMO, 3'd2, 32'h7F80_0000, 64'd0));
		send_item(mk(CMD_LOAD, SRC_SIM,  3'd3, 32'h8000_0000, 64'd1));
		send_item(mk(CMD_LOAD, SRC_PHYS, 3'd4, 32'h3F80_0000, 64'd0));
		send_item(mk(CMD_LOAD, SRC_NONE, 3'd5, 32'h0000_0001, 64'd0));
		send_item(mk(CMD_LOAD, SRC_NONE, 3'd6, 32'h7FFF_FFFF, 64'd0));
		send_item(mk(CMD_LOAD, SRC_NONE, 3'd7, $urandom, 64'hFFFF_FFFF_FFFF_FFFF));
		// Demo source is live with no time at all
		send_item(mk(CMD_GET, SRC_NONE, 3'd0, 32'd0, 64'd0));
		// Submit rejections: no source, wrong source, zero time; then a stamp
		send_item(mk(CMD_SUBMIT, SRC_NONE, 3'd0, 32'h1234_5678, 64'd5));
		send_item(mk(CMD_SUBMIT, SRC_SIM,  3'd0, 32'h1234_5678, 64'd5));
		send_item(mk(CMD_SUBMIT, SRC_DEMO, 3'd0, 32'h1234_5678, 64'd0));
		send_item(mk(CMD_SUBMIT, SRC_DEMO, 3'd7, 32'hDEAD_BEEF, 64'hFFFF_FFFF_FFFF_FFFF));
		// Select of none is refused; a real select clears the stamp
		send_item(mk(CMD_SELECT, SRC_NONE, 3'd0, 32'd0, 64'd0));
		send_item(mk(CMD_SELECT, SRC_PHYS, 3'd0, 32'd0, 64'd0));
		send_item(mk(CMD_GET, SRC_NONE, 3'd0, 32'd0, 64'd1));
		// Staleness edges: age equal to the timeout, one past, and wrapped
		send_item(mk(CMD_SUBMIT, SRC_PHYS, 3'd7, 32'hCAFE_F00D, 64'd1000));
		send_item(mk(CMD_GET, SRC_NONE, 3'd0, 32'd0, 64'd1000 + RST_TIMEOUT));
		send_item(mk(CMD_GET, SRC_NONE, 3'd0, 32'd0, 64'd1001 + RST_TIMEOUT));
		send_item(mk(CMD_GET, SRC_NONE, 3'd0, 32'd0, 64'd999));

		// Register phases, the last one without idling
		age_plan[4] = TIME_W'($urandom_range(1, 20000));
		age_plan[5] = rand64();
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			if (ph == 5) quiet = 1'b1;
			write_reg(REG_ACT_COUNT, {{(CFG_W-CNT_W){1'b0}}, count_plan[ph]});
			write_reg(REG_TIMEOUT, age_plan[ph]);
			send_item(mk(CMD_SELECT, SRC_W'($urandom_range(1, 3)), IDX_FW'($urandom),
			             $urandom, rand64()));
			random_items(17);
		end

		settle();
		if (guard.errors == 0 && guard.pending_outputs.size() == 0) begin
			$display("tb_failsafe_command_arbiter_core: PASS");
		end else begin
			$display("tb_failsafe_command_arbiter_core: FAIL");
		end
		$finish;
	end

endmodule
